// File: rtl/jkiss_pkg.sv
// Shared constants, opcode codes and control types of the JKISS random generator.
package jkiss_pkg;

	typedef enum logic {
		OP_DRAW = 1'b0,
		OP_SEED = 1'b1
	} op_t;

	// Control from the handshake stage to the generator core.
	typedef struct packed {
		logic fire;
		op_t  op;
	} step_ctrl_t;

	localparam logic [31:0] LCG_RESET   = 32'd433494437;
	localparam logic [31:0] XS_RESET    = 32'd2971215073;
	localparam logic [31:0] MWC_RESET   = 32'd2147483647;
	localparam logic [31:0] CARRY_RESET = 32'd2521008887;
	localparam logic [31:0] LCG_MUL     = 32'd314527869;
	localparam logic [31:0] LCG_ADD     = 32'd1234567;
	localparam logic [31:0] MWC_MUL     = 32'd4294584393;
	localparam logic [31:0] SEED_MUL_C  = 32'd1442968193;

endpackage

// File: rtl/jkiss_random_generator.sv
// JKISS random generator top level: input register, generator core and result register.
//
// The block accepts one request per cycle unless in_stall is high: a draw advances
// the generator and returns one 31-bit value, a reseed reloads the state and returns
// nothing. A draw's result passes through the input register and then the result
// register. The rate is set by the state recurrence, a registered update whose longest
// path is the 32x32 multiply-with-carry multiplier followed by the three-word sum. A
// request stalls only while a draw waits behind an undelivered, stalled result;
// reseeds pass a stalled result. No clearing pass follows reset.
module jkiss_random_generator import jkiss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [31:0] seed_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [30:0] random_value
);

	logic        valid_s1;
	op_t         op_s1;
	logic [31:0] seed_s1;

	logic        out_valid_q;
	logic [30:0] random_q;

	logic        hold;
	step_ctrl_t  ctrl;
	logic [30:0] draw_value;

	// A draw in the input register waits while the result register is full and stalled.
	assign hold      = valid_s1 && (op_s1 == OP_DRAW) && out_valid_q && out_stall;
	assign in_stall  = hold;
	assign ctrl.fire = valid_s1 && !hold;
	assign ctrl.op   = op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!hold) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !hold) begin
			op_s1   <= op_t'(opcode);
			seed_s1 <= seed_value;
		end
	end

	jkiss_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.seed       (seed_s1),
		.draw_value (draw_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.fire && (op_s1 == OP_DRAW)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fire && (op_s1 == OP_DRAW)) begin
			random_q <= draw_value;
		end
	end

	assign out_valid    = out_valid_q;
	assign random_value = random_q;

endmodule

// File: rtl/jkiss_core.sv
// Generator state words with their draw and reseed update logic.
module jkiss_core import jkiss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  step_ctrl_t  ctrl,
	input  logic [31:0] seed,
	output logic [30:0] draw_value
);

	logic [31:0] lcg_q;
	logic [31:0] xs_q;
	logic [31:0] mwc_q;
	logic [31:0] carry_q;

	logic [31:0] lcg_next;
	logic [31:0] xs_1;
	logic [31:0] xs_2;
	logic [31:0] xs_next;
	logic [63:0] mwc_t;
	logic [31:0] sum;

	logic [31:0] seed_n;
	logic [31:0] lcg_seed;
	logic [31:0] xs_seed;
	logic [31:0] mwc_seed;
	logic [31:0] carry_seed;

	always_comb begin
		lcg_next = LCG_MUL * lcg_q + LCG_ADD;

		xs_1    = xs_q ^ (xs_q << 5);
		xs_2    = xs_1 ^ (xs_1 >> 7);
		xs_next = xs_2 ^ (xs_2 << 22);

		mwc_t = {32'd0, MWC_MUL} * {32'd0, mwc_q} + {32'd0, carry_q};

		// The result keeps only the low 31 bits of the sum.
		sum        = lcg_next + xs_next + mwc_t[31:0];
		draw_value = sum[30:0];

		// Multiplies by 257 and 65537 are plain shift-and-add.
		seed_n     = ~seed;
		lcg_seed   = LCG_RESET ^ seed_n;
		xs_seed    = XS_RESET + seed_n + (seed_n << 8);
		mwc_seed   = MWC_RESET ^ (seed + (seed << 16));
		carry_seed = CARRY_RESET + seed * SEED_MUL_C;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_q   <= LCG_RESET;
			xs_q    <= XS_RESET;
			mwc_q   <= MWC_RESET;
			carry_q <= CARRY_RESET;
		end else if (ctrl.fire) begin
			unique case (ctrl.op)
				OP_DRAW: begin
					lcg_q   <= lcg_next;
					xs_q    <= xs_next;
					mwc_q   <= mwc_t[31:0];
					carry_q <= mwc_t[63:32];
				end
				OP_SEED: begin
					if (seed == 32'd0) begin
						lcg_q   <= LCG_RESET;
						xs_q    <= XS_RESET;
						mwc_q   <= MWC_RESET;
						carry_q <= CARRY_RESET;
					end else begin
						lcg_q   <= lcg_seed;
						xs_q    <= xs_seed;
						mwc_q   <= mwc_seed;
						carry_q <= carry_seed;
					end
				end
				default: begin
					lcg_q <= lcg_q;
				end
			endcase
		end
	end

endmodule

// File: rtl/jkiss_checker.sv
// Port-level assertions for the JKISS random generator and their bind.
module jkiss_checker import jkiss_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        opcode,
	input logic [31:0] seed_value,
	input logic        out_valid,
	input logic        out_stall,
	input logic [30:0] random_value
);

	// A stalled result stays valid and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(random_value))
		else $error("stalled result changed or dropped");

	// A stalled request stays valid and keeps its payload.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(opcode) && $stable(seed_value))
		else $error("stalled request changed or dropped");

	// Requests are held back only by a full, stalled result register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("request stalled without a stalled result");

	// An accepted draw leaves a result in the result register once it has passed the input register.
	a_draw_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (op_t'(opcode) == OP_DRAW) |=> ##1 out_valid)
		else $error("accepted draw produced no result");

	// The result register is empty straight out of reset.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid && !in_stall)
		else $error("result pending after reset");

endmodule

bind jkiss_random_generator jkiss_checker u_checker (.*);

// File: sim/jkiss_random_generator_checker.sv
// Checker for the JKISS random generator: watches both channels, predicts each draw and compares.
module jkiss_random_generator_checker import jkiss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        opcode,
	input  logic [31:0] seed_value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [30:0] random_value,
	output int          error_count,
	output int          pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] CONG_INIT    = 32'd433494437;
	localparam logic [31:0] SHIFT_INIT   = 32'd2971215073;
	localparam logic [31:0] MULW_INIT    = 32'd2147483647;
	localparam logic [31:0] CARRY_INIT   = 32'd2521008887;
	localparam logic [31:0] CONG_FACTOR  = 32'd314527869;
	localparam logic [31:0] CONG_OFFSET  = 32'd1234567;
	localparam logic [31:0] MULW_FACTOR  = 32'd4294584393;
	localparam logic [31:0] SEED_SHIFT_K = 32'd257;
	localparam logic [31:0] SEED_MULW_K  = 32'd65537;
	localparam logic [31:0] SEED_CARRY_K = 32'd1442968193;

	typedef struct packed {
		logic [31:0] cong;
		logic [31:0] shift;
		logic [31:0] mulw;
		logic [31:0] carry;
	} gen_words_t;

	localparam gen_words_t INIT_WORDS = '{CONG_INIT, SHIFT_INIT, MULW_INIT, CARRY_INIT};

	gen_words_t   gen;
	logic [30:0]  expected_values[$];
	logic [30:0]  want;

	function automatic gen_words_t advance_words(gen_words_t w);
		gen_words_t  n;
		logic [31:0] v;
		logic [63:0] prod;
		n.cong = CONG_FACTOR * w.cong + CONG_OFFSET;
		v = w.shift;
		v = v ^ (v << 5);
		v = v ^ (v >> 7);
		v = v ^ (v << 22);
		n.shift = v;
		prod = {32'd0, MULW_FACTOR} * {32'd0, w.mulw} + {32'd0, w.carry};
		n.carry = prod[63:32];
		n.mulw = prod[31:0];
		return n;
	endfunction

	function automatic gen_words_t seeded_words(logic [31:0] s);
		gen_words_t n;
		if (s == 32'd0) begin
			n = INIT_WORDS;
		end else begin
			n.cong  = CONG_INIT ^ ~s;
			n.shift = SHIFT_INIT + (~s) * SEED_SHIFT_K;
			n.mulw  = MULW_INIT ^ (s * SEED_MULW_K);
			n.carry = CARRY_INIT + s * SEED_CARRY_K;
		end
		return n;
	endfunction

	function automatic logic [30:0] draw_output(gen_words_t w);
		logic [31:0] sum;
		sum = w.cong + w.shift + w.mulw;
		return sum[30:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen = INIT_WORDS;
			expected_values.delete();
			error_count <= 0;
			pending_count <= 0;
		end else begin
			// The result leaving this cycle always belongs to an older request, so
			// compare before pushing anything accepted at the same edge.
			if (out_valid && !out_stall) begin
				if (expected_values.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual %08h",
						$time, random_value);
					error_count <= error_count + 1;
				end else begin
					want = expected_values.pop_front();
					if (random_value !== want) begin
						$display("%0t: random_value mismatch: expected %08h, actual %08h",
							$time, want, random_value);
						error_count <= error_count + 1;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (op_t'(opcode) == OP_DRAW) begin
					gen = advance_words(gen);
					expected_values.push_back(draw_output(gen));
				end else begin
					gen = seeded_words(seed_value);
				end
			end
			pending_count <= expected_values.size();
		end
	end

endmodule

// File: sim/jkiss_random_generator_tb.sv
// Testbench top for the JKISS random generator: clock, reset, requests, stalls and verdict.
module jkiss_random_generator_tb;
	import jkiss_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 300;
	// Seeds that zero the xorshift word and the multiply-with-carry value word.
	localparam logic [31:0] SHIFT_ZERO_SEED = ~((32'd0 - 32'd2971215073) * 32'hFF00FF01);
	localparam logic [31:0] MULW_ZERO_SEED  = 32'h7FFFFFFF * 32'hFFFF0001;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        opcode = 1'b0;
	logic [31:0] seed_value = 32'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [30:0] random_value;

	int error_count;
	int pending_count;
	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;
	int quiet_cycles = 0;

	always #4 clk = ~clk;

	jkiss_random_generator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.seed_value   (seed_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.random_value (random_value)
	);

	jkiss_random_generator_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.seed_value    (seed_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.random_value  (random_value),
		.error_count   (error_count),
		.pending_count (pending_count)
	);

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rcv_stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Holds the request until it is taken; the payload is scrambled only while valid is low.
	task automatic send_request(input op_t op, input logic [31:0] sd);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < snd_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			opcode <= 1'($urandom);
			seed_value <= $urandom;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		seed_value <= sd;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain_results();
		do @(posedge clk); while (pending_count != 0);
	endtask

	initial begin
		int pick;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset sequence, seed zero, extreme and degenerate seeds.
		repeat (3) send_request(OP_DRAW, $urandom);
		send_request(OP_SEED, 32'd0);
		repeat (2) send_request(OP_DRAW, 32'hFFFFFFFF);
		send_request(OP_SEED, 32'hFFFFFFFF);
		repeat (2) send_request(OP_DRAW, 32'd0);
		send_request(OP_SEED, 32'd1);
		send_request(OP_DRAW, 32'd0);
		send_request(OP_SEED, 32'h80000000);
		send_request(OP_DRAW, 32'd0);
		send_request(OP_SEED, SHIFT_ZERO_SEED);
		repeat (3) send_request(OP_DRAW, 32'd0);
		send_request(OP_SEED, MULW_ZERO_SEED);
		repeat (2) send_request(OP_DRAW, 32'd0);
		send_request(OP_SEED, 32'hAAAAAAAA);
		send_request(OP_SEED, 32'h55555555);
		send_request(OP_DRAW, 32'd0);
		send_request(OP_SEED, 32'd0);
		send_request(OP_DRAW, 32'd0);
		in_valid <= 1'b0;
		drain_results();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
				1: begin snd_idle_pct = 55; rcv_stall_pct = 0;  end
				2: begin snd_idle_pct = 0;  rcv_stall_pct = 55; end
				default: begin snd_idle_pct = 23; rcv_stall_pct = 23; end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick = $urandom_range(99);
				if (pick < 80) begin
					send_request(OP_DRAW, $urandom);
				end else if (pick < 84) begin
					send_request(OP_SEED, 32'd0);
				end else if (pick < 96) begin
					send_request(OP_SEED, $urandom);
				end else if (pick < 98) begin
					send_request(OP_SEED, 32'd1 << $urandom_range(31));
				end else begin
					send_request(OP_SEED, ~(32'd1 << $urandom_range(31)));
				end
			end
			// The sender holds off here until every outstanding draw has returned.
			in_valid <= 1'b0;
			drain_results();
		end

		repeat (10) @(posedge clk);
		if (error_count == 0 && pending_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
